/* hw/rtl/hid_keyboard_report_builder_assert.svh */
// assertion macros for the hid keyboard report builder checker
// no dependencies; included by files that hold concurrent assertions
`ifndef HID_KEYBOARD_REPORT_BUILDER_ASSERT_SVH
`define HID_KEYBOARD_REPORT_BUILDER_ASSERT_SVH

// next-cycle implication, ignored while reset is high
`define HKRB_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("hkrb assertion failed");

// next-cycle implication, also checked across reset
`define HKRB_ASSERT_NEXT_ALWAYS(lbl, ck, ante, cons) \
  lbl: assert property (@(posedge ck) (ante) |=> (cons)) \
    else $error("hkrb assertion failed");

`endif

/* hw/rtl/hkrb_pkg.sv */
// shared constants, types and controller/datapath links for the report builder
// no dependencies
package hkrb_pkg;

  localparam int SLOT_COUNT = 6;
  localparam int KEY_SPACE  = 256;
  localparam int OUT_SLOTS  = 6;
  localparam int KEY_W      = 8;
  localparam int CNT_W      = $clog2(SLOT_COUNT + 1);
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = KEY_W * (OUT_SLOTS + 1);

  localparam logic [4:0] MOD_PREFIX = 5'b11100;

  localparam logic OP_PRESS   = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  typedef logic [KEY_W-1:0] key_t;

  typedef struct packed {
    logic load;
    logic clr_step;
    logic hold_we;
    logic hold_val;
    logic mod_set;
    logic mod_clr;
    logic append;
    logic remove;
    logic emit;
  } hkrb_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic code_zero;
    logic op;
    logic held;
    logic is_mod;
    logic full;
    logic hit;
    logic out_free;
  } hkrb_sts_t;

endpackage

/* hw/rtl/hkrb_ram.sv */
// generic single-port-write ram with registered read
// no dependencies
module hkrb_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/hkrb_datapath.sv */
// held-key map, modifier byte, key slots and output report register
// depends on hkrb_pkg and hkrb_ram
module hkrb_datapath
  import hkrb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  hkrb_cmd_t             cmd,
  output hkrb_sts_t             sts,
  input  logic                  in_op,
  input  key_t                  in_code,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [OUT_DATA_W-1:0] out_data
);

  logic                  op;
  key_t                  code;
  key_t                  clr_addr;
  logic                  held;
  logic                  ram_we;
  key_t                  ram_waddr;
  logic                  ram_wdata;
  logic [7:0]            modifier;
  key_t                  slots [SLOT_COUNT];
  logic [CNT_W-1:0]      count;
  logic [SLOT_COUNT-1:0] match;
  logic [SLOT_COUNT-1:0] hit;
  logic [SLOT_COUNT-1:0] last_oh;
  key_t                  last_val;
  logic [OUT_DATA_W-1:0] report;

  // held-key map, swept to zero after reset
  assign ram_we    = cmd.clr_step | cmd.hold_we;
  assign ram_waddr = cmd.clr_step ? clr_addr : code;
  assign ram_wdata = cmd.clr_step ? 1'b0 : cmd.hold_val;

  hkrb_ram #(
    .WIDTH (1),
    .DEPTH (KEY_SPACE)
  ) u_held (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (code),
    .rdata (held)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clr_step) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op   <= in_op;
      code <= in_code;
    end
  end

  // parallel slot compare, first match kept
  always_comb begin
    last_val = '0;
    for (int j = 0; j < SLOT_COUNT; j++) begin
      match[j]   = (slots[j] == code) && (CNT_W'(j) < count);
      last_oh[j] = (CNT_W'(j + 1) == count);
      last_val   = last_val | (slots[j] & {KEY_W{last_oh[j]}});
    end
  end

  always_ff @(posedge clk) begin
    hit <= match & (~match + 1'b1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      modifier <= '0;
      count    <= '0;
      for (int j = 0; j < SLOT_COUNT; j++) begin
        slots[j] <= '0;
      end
    end else begin
      if (cmd.mod_set) begin
        modifier[code[2:0]] <= 1'b1;
      end else if (cmd.mod_clr) begin
        modifier[code[2:0]] <= 1'b0;
      end
      if (cmd.append) begin
        for (int j = 0; j < SLOT_COUNT; j++) begin
          if (CNT_W'(j) == count) begin
            slots[j] <= code;
          end
        end
        count <= count + 1'b1;
      end else if (cmd.remove) begin
        for (int j = 0; j < SLOT_COUNT; j++) begin
          if (last_oh[j]) begin
            slots[j] <= '0;
          end else if (hit[j]) begin
            slots[j] <= last_val;
          end
        end
        count <= count - 1'b1;
      end
    end
  end

  // report packing, slots beyond the slot count read as zero
  assign report[KEY_W-1:0] = modifier;
  for (genvar j = 0; j < OUT_SLOTS; j++) begin : g_pack
    if (j < SLOT_COUNT) begin : g_used
      assign report[KEY_W*(j+2)-1 -: KEY_W] = slots[j];
    end else begin : g_zero
      assign report[KEY_W*(j+2)-1 -: KEY_W] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data <= report;
    end
  end

  assign sts.clr_last  = (clr_addr == key_t'(KEY_SPACE - 1));
  assign sts.code_zero = (code == '0);
  assign sts.op        = op;
  assign sts.held      = held;
  assign sts.is_mod    = (code[7:3] == MOD_PREFIX);
  assign sts.full      = (count == CNT_W'(SLOT_COUNT));
  assign sts.hit       = |hit;
  assign sts.out_free  = !out_valid || out_ready;

endmodule

/* hw/rtl/hkrb_ctrl.sv */
// sequencing state machine for clear sweep, map lookup, update and report
// depends on hkrb_pkg
module hkrb_ctrl
  import hkrb_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  hkrb_sts_t sts,
  output hkrb_cmd_t cmd
);

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_READ   = 3'd2;
  localparam logic [2:0] ST_DECIDE = 3'd3;
  localparam logic [2:0] ST_REMOVE = 3'd4;
  localparam logic [2:0] ST_EMIT   = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        state_next = ST_IDLE;
        if (sts.code_zero) begin
          state_next = ST_IDLE;
        end else if (sts.op == OP_PRESS) begin
          if (!sts.held) begin
            cmd.hold_we  = 1'b1;
            cmd.hold_val = 1'b1;
            if (sts.is_mod) begin
              cmd.mod_set = 1'b1;
              state_next  = ST_EMIT;
            end else if (!sts.full) begin
              cmd.append = 1'b1;
              state_next = ST_EMIT;
            end
          end
        end else if (sts.held) begin
          cmd.hold_we = 1'b1;
          if (sts.is_mod) begin
            cmd.mod_clr = 1'b1;
            state_next  = ST_EMIT;
          end else begin
            state_next = ST_REMOVE;
          end
        end
      end
      ST_REMOVE: begin
        if (sts.hit) begin
          cmd.remove = 1'b1;
          state_next = ST_EMIT;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

/* hw/rtl/hid_keyboard_report_builder.sv */
// steps: load the accepted word, read the held-key map, decide and update, remove the slot
// for a non-modifier release, then register the report once the output register is free
// the next event is taken only after this sequence, while a pending report waits in the
// output register; reset: synchronous, then all 256 held-key map entries are swept clear
// with s_tready low; depends on hkrb_pkg, hkrb_ctrl, hkrb_datapath
module hid_keyboard_report_builder
  import hkrb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,  // key_code
  input  logic                  s_tuser,  // op
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata   // modifier_bits, slot0 .. slot5
);

  hkrb_cmd_t cmd;
  hkrb_sts_t sts;

  hkrb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  hkrb_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_op     (s_tuser),
    .in_code   (s_tdata),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata)
  );

endmodule

/* hw/rtl/hkrb_checker.sv */
// port-level checks on the report builder, bound to the top level
// depends on hkrb_pkg and hid_keyboard_report_builder_assert.svh
`include "hid_keyboard_report_builder_assert.svh"

module hkrb_checker
  import hkrb_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tvalid,
  input logic                  s_tready,
  input logic [IN_DATA_W-1:0]  s_tdata,
  input logic                  s_tuser,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata
);

  logic acc_in;

  assign acc_in = s_tvalid && s_tready;

  `HKRB_ASSERT_NEXT_ALWAYS(a_rst_blocks_input, clk, rst, !s_tready)
  `HKRB_ASSERT_NEXT_ALWAYS(a_rst_clears_output, clk, rst, !m_tvalid)
  `HKRB_ASSERT_NEXT(a_one_word_at_a_time, clk, rst, acc_in, !s_tready)
  `HKRB_ASSERT_NEXT(a_no_instant_report, clk, rst, acc_in, !$rose(m_tvalid))
  `HKRB_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule

bind hid_keyboard_report_builder hkrb_checker u_chk (.*);

/* tb/sv/tb_top.sv */
// self-checking testbench for hid_keyboard_report_builder: directed and random key events
// against a built-in report predictor, with idle and stall phases on both stream sides
// depends on hkrb_pkg and the hid_keyboard_report_builder rtl
module tb_top
  import hkrb_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 20;
  localparam int PHASES = 4;

  typedef struct packed {
    logic op;
    key_t code;
  } key_event_t;

  typedef struct packed {
    logic [OUT_SLOTS-1:0][KEY_W-1:0] slot;
    key_t modifier;
  } report_t;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;  // key_code
  logic                  s_tuser;  // op
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;  // modifier_bits, slot0 .. slot5

  key_event_t pending_events[$];
  report_t    expected_reports[$];
  int         src_idle_pct = 0;
  int         snk_stall_pct = 0;
  int         err_count = 0;
  int         cycle_count = 0;
  logic       word_taken = 1'b0;

  // predictor state
  logic [KEY_SPACE-1:0] held_keys = '0;
  key_t                 mod_byte = '0;
  key_t                 slot_keys[SLOT_COUNT];
  int                   slots_used = 0;

  // stimulus-side view of which keys are down
  logic [KEY_SPACE-1:0] gen_down = '0;
  key_t                 gen_list[$];

  hid_keyboard_report_builder DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    foreach (slot_keys[i]) slot_keys[i] = '0;
  end

  function automatic bit apply_key_event(input logic op, input key_t code, output report_t rpt);
    bit changed;
    bit is_mod;
    changed = 1'b0;
    is_mod = (code[7:3] == MOD_PREFIX);
    rpt = '0;
    if (code == '0) return 1'b0;
    if (op == OP_PRESS) begin
      if (held_keys[code]) return 1'b0;
      if (is_mod) begin
        mod_byte[code[2:0]] = 1'b1;
        changed = 1'b1;
      end else if (slots_used < SLOT_COUNT) begin
        slot_keys[slots_used] = code;
        slots_used++;
        changed = 1'b1;
      end
      held_keys[code] = 1'b1;
    end else begin
      if (!held_keys[code]) return 1'b0;
      if (is_mod) begin
        mod_byte[code[2:0]] = 1'b0;
        changed = 1'b1;
      end else begin
        for (int i = 0; i < slots_used; i++) begin
          if (slot_keys[i] == code) begin
            slots_used--;
            slot_keys[i] = slot_keys[slots_used];
            slot_keys[slots_used] = '0;
            changed = 1'b1;
            break;
          end
        end
      end
      held_keys[code] = 1'b0;
    end
    rpt.modifier = mod_byte;
    for (int j = 0; j < OUT_SLOTS; j++)
      rpt.slot[j] = (j < SLOT_COUNT) ? slot_keys[j] : '0;
    return changed;
  endfunction

  // monitor: predicts on accepted input words, checks accepted output words
  always @(posedge clk) begin : monitor
    report_t want;
    report_t got;
    if (rst) begin
      word_taken <= 1'b0;
    end else begin
      word_taken <= s_tvalid && s_tready;
      if (s_tvalid && s_tready) begin
        if (apply_key_event(s_tuser, s_tdata, want)) expected_reports.push_back(want);
      end
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        if (expected_reports.size() == 0) begin
          $error("unexpected report: %h", m_tdata);
          err_count++;
        end else begin
          want = expected_reports.pop_front();
          if (got.modifier !== want.modifier) begin
            $error("modifier_bits: expected %h, actual %h", want.modifier, got.modifier);
            err_count++;
          end
          for (int j = 0; j < OUT_SLOTS; j++) begin
            if (got.slot[j] !== want.slot[j]) begin
              $error("slot%0d: expected %h, actual %h", j, want.slot[j], got.slot[j]);
              err_count++;
            end
          end
        end
      end
    end
  end

  // driver: inputs change on the falling edge
  always @(negedge clk) begin : driver
    key_event_t ev;
    if (!rst) begin
      if (!s_tvalid || word_taken) begin
        if (pending_events.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          ev = pending_events.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= ev.code;
          s_tuser  <= ev.op;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
      m_tready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic push_event(input logic op, input key_t code);
    key_event_t ev;
    ev.op = op;
    ev.code = code;
    pending_events.push_back(ev);
    if (code != '0) begin
      if (op == OP_PRESS && !gen_down[code]) begin
        gen_down[code] = 1'b1;
        gen_list.push_back(code);
      end else if (op == OP_RELEASE && gen_down[code]) begin
        gen_down[code] = 1'b0;
        foreach (gen_list[i]) begin
          if (gen_list[i] == code) begin
            gen_list.delete(i);
            break;
          end
        end
      end
    end
  endtask

  task automatic push_random(input int count);
    int r;
    int release_bias;
    key_t code;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(99);
      release_bias = 20 + 10 * gen_list.size();
      if (release_bias > 80) release_bias = 80;
      if (r < 10) begin
        push_event(1'($urandom_range(1)), 8'($urandom_range(255)));
      end else if (r < 16 && gen_list.size() != 0) begin
        // repeated press of a key already down
        push_event(OP_PRESS, gen_list[$urandom_range(gen_list.size() - 1)]);
      end else if (gen_list.size() != 0 && $urandom_range(99) < release_bias) begin
        push_event(OP_RELEASE, gen_list[$urandom_range(gen_list.size() - 1)]);
      end else begin
        r = $urandom_range(99);
        if (r < 55) code = 8'h04 + 8'($urandom_range(9));
        else if (r < 80) code = {MOD_PREFIX, 3'($urandom_range(7))};
        else code = 8'($urandom_range(1, 255));
        push_event(OP_PRESS, code);
      end
    end
  endtask

  task automatic wait_idle();
    while (pending_events.size() != 0 || s_tvalid || expected_reports.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    int src_pct[PHASES];
    int snk_pct[PHASES];
    src_pct  = '{0, 61, 0, 24};
    snk_pct  = '{0, 0, 61, 24};
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = 1'b0;
    m_tready = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // zero code, modifier edges, repeats, full slot list, middle removal
    push_event(OP_PRESS, 8'h00);
    push_event(OP_RELEASE, 8'h00);
    push_event(OP_PRESS, 8'hE0);
    push_event(OP_PRESS, 8'hE7);
    push_event(OP_PRESS, 8'hE0);
    push_event(OP_RELEASE, 8'hE7);
    push_event(OP_RELEASE, 8'hE7);
    push_event(OP_PRESS, 8'h01);
    push_event(OP_PRESS, 8'hFF);
    push_event(OP_PRESS, 8'h80);
    push_event(OP_PRESS, 8'hDF);
    push_event(OP_PRESS, 8'hE8);
    push_event(OP_PRESS, 8'h7F);
    push_event(OP_PRESS, 8'h55);
    push_event(OP_RELEASE, 8'h80);
    push_event(OP_PRESS, 8'hAA);
    push_event(OP_RELEASE, 8'h55);
    push_event(OP_RELEASE, 8'h33);
    push_event(OP_RELEASE, 8'h7F);
    push_event(OP_RELEASE, 8'hE0);
    push_event(OP_RELEASE, 8'h01);
    push_event(OP_RELEASE, 8'hFF);
    push_event(OP_RELEASE, 8'hDF);
    push_event(OP_RELEASE, 8'hE8);
    push_event(OP_RELEASE, 8'hAA);

    for (int p = 0; p < PHASES; p++) begin
      src_idle_pct = src_pct[p];
      snk_stall_pct = snk_pct[p];
      push_random(95);
      wait_idle();
    end

    if (expected_reports.size() != 0) begin
      $error("%0d reports never arrived", expected_reports.size());
      err_count++;
    end
    if (err_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
